// ===== src/plsu_pkg.sv =====
// shared constants, types and codes of the positional list store
package plsu_pkg;

  localparam int CAPACITY = 64;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 7;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 7;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int GRP      = 8;
  localparam int GRP_W    = $clog2(GRP);
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
  localparam int GSEL_W   = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [LEN_W-1:0]         len_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ = 3'd0,
    CMD_HEAD = 3'd1,
    CMD_TAIL = 3'd2,
    CMD_AT   = 3'd3,
    CMD_DEL  = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    RD_ZERO  = 2'd0,
    RD_ONES  = 2'd1,
    RD_ENTRY = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    word_t            value;
  } in_word_t;

  typedef struct packed {
    word_t             read_value;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  entry_count;
  } out_word_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic  ins;
    logic  del;
    idx_t  idx;
    word_t value;
  } cell_ctrl_t;

endpackage

// ===== src/positional_list_store_unit.sv =====
// Positional list store: a row of cells holding up to CAPACITY ordered words.
// Pipeline: an accepted input word is registered in stage s1, then in the output register.
// Throughput: one word per cycle while the output is not stalled; every cell shifts or holds in parallel, and a
// read passes a two-level registered select over the row.
// Reset: the list length clears to zero and both pipeline stages empty;
// cell contents are not reset.
module positional_list_store_unit
  import plsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  word_t      entries [CAPACITY];
  cell_ctrl_t ctrl;
  word_t      rd_word;

  len_t              len_q, len_d;
  logic              s1_valid_q, s1_valid_d;
  rd_sel_e           s1_rd_q, rd_sel;
  logic [STAT_W-1:0] s1_status_q;
  logic [CNT_W-1:0]  s1_count_q;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_q;

  logic              in_acc, s1_move, full;
  logic [CMP_W-1:0]  pos_c, len_c;
  status_e           status;

  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pos_c = CMP_W'(in_word_i.position);
  assign len_c = CMP_W'(len_q);
  assign full  = (len_q == LEN_W'(CAPACITY));

  // decode the command against the current length
  always_comb begin
    ctrl       = '0;
    ctrl.value = in_word_i.value;
    ctrl.idx   = pos_c[IDX_W-1:0];
    rd_sel     = RD_ZERO;
    status     = ST_DONE;
    len_d      = len_q;
    case (cmd_e'(in_word_i.command))
      CMD_READ: begin
        if (pos_c < len_c) begin
          rd_sel = RD_ENTRY;
        end else begin
          rd_sel = RD_ONES;
          status = ST_RANGE;
        end
      end
      CMD_HEAD: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          ctrl.idx = '0;
        end
      end
      CMD_TAIL: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
          ctrl.idx = len_c[IDX_W-1:0];
        end
      end
      CMD_AT: begin
        if (pos_c > len_c) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
        end
      end
      CMD_DEL: begin
        if (pos_c >= len_c) begin
          status = ST_RANGE;
        end else begin
          ctrl.del = 1'b1;
        end
      end
      default: ;
    endcase
    if (!in_acc) begin
      ctrl.ins = 1'b0;
      ctrl.del = 1'b0;
    end
    if (ctrl.ins) begin
      len_d = len_q + LEN_W'(1);
    end else if (ctrl.del) begin
      len_d = len_q - LEN_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = entries[i+1];
    end
    plsu_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (idx_t'(i)),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entries[i])
    );
  end

  plsu_read_tree u_read (
    .clk_i     (clk_i),
    .load_i    (in_acc),
    .idx_i     (pos_c[IDX_W-1:0]),
    .entries_i (entries),
    .word_o    (rd_word)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_rd_q     <= rd_sel;
      s1_status_q <= status;
      s1_count_q  <= CNT_W'(len_d);
    end
    if (s1_move) begin
      case (s1_rd_q)
        RD_ENTRY: out_q.read_value <= rd_word;
        RD_ONES:  out_q.read_value <= '1;
        default:  out_q.read_value <= '0;
      endcase
      out_q.status      <= s1_status_q;
      out_q.entry_count <= s1_count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== src/plsu_cell.sv =====
// one list slot: holds, loads the new value, or takes a neighbor's entry
module plsu_cell
  import plsu_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  idx_t       idx_i,
  input  word_t      left_i,
  input  word_t      right_i,
  output word_t      entry_o
);

  word_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && idx_i == ctrl_i.idx) begin
      entry_d = ctrl_i.value;
    end else if (ctrl_i.ins && idx_i > ctrl_i.idx) begin
      entry_d = left_i;
    end else if (ctrl_i.del && idx_i >= ctrl_i.idx) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== src/plsu_read_tree.sv =====
// two-level registered read select over the cell row
module plsu_read_tree
  import plsu_pkg::*;
(
  input  logic  clk_i,
  input  logic  load_i,
  input  idx_t  idx_i,
  input  word_t entries_i [CAPACITY],
  output word_t word_o
);

  word_t             grp_q [NGRP];
  word_t             grp_d [NGRP];
  logic [GSEL_W-1:0] gsel_q;
  logic [GRP_W-1:0]  lo;

  assign lo = GRP_W'(idx_i % GRP);

  // first level: one word out of each group of eight
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if ((g * GRP + k) < CAPACITY && lo == GRP_W'(k)) begin
          grp_d[g] = entries_i[g * GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q  <= grp_d;
      gsel_q <= GSEL_W'(idx_i / GRP);
    end
  end

  assign word_o = grp_q[gsel_q];

endmodule

// ===== src/plsu_checker.sv =====
// port-level checks of the positional list store, bound to the top level
module plsu_checker
  import plsu_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // input backs up only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // an insert dropped with full status only happens on a full store and reads nothing
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_FULL |->
      out_word_o.entry_count == CNT_W'(CAPACITY) && out_word_o.read_value == '0)
    else $error("full status with wrong count or value");

endmodule

bind positional_list_store_unit plsu_checker u_plsu_checker (.*);
